/* src/block_reader_writer_lock_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lock table checker
// Implication and next-cycle implication forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BLOCK_READER_WRITER_LOCK_TABLE_UNIT_ASSERT_SVH
`define BLOCK_READER_WRITER_LOCK_TABLE_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle
`define BRWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent
`define BRWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/brwl_pkg.sv */
// ----------------------------------------------------------------------------
// brwl_pkg
// Sizes, types, status and command codes shared by the lock table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brwl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 48;
    localparam int COUNT_BITS    = 16;
    localparam int POS_BITS      = 48;
    localparam int OUT_CNT_BITS  = 16;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [IDX_BITS-1:0]     t_idx;
    typedef logic [2:0]              t_status;
    typedef logic [1:0]              t_cmd;
    typedef logic [POS_BITS-1:0]     t_pos;
    typedef logic [OUT_CNT_BITS-1:0] t_out_cnt;

    localparam t_count COUNT_MAX = '1;
    localparam t_idx   LAST_IDX  = t_idx'(TABLE_ENTRIES - 1);

    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_CONFLICT = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_NOT_HELD = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;

    localparam t_cmd CMD_READ_LOCK    = 2'd0;
    localparam t_cmd CMD_WRITE_LOCK   = 2'd1;
    localparam t_cmd CMD_READ_UNLOCK  = 2'd2;
    localparam t_cmd CMD_WRITE_UNLOCK = 2'd3;

    typedef struct packed {
        t_key   key;
        t_count readers;
        t_count writers;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_slot data;
    } t_slot_wr;

    function automatic t_key key_of(input t_pos pos);
        logic [63:0] w;
        w = 64'(pos);
        return w[KEY_BITS-1:0];
    endfunction

    function automatic t_out_cnt count_out(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_CNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/brwl_slot_mem.sv */
// ----------------------------------------------------------------------------
// brwl_slot_mem
// Slot store: key and reader/writer counts per slot, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brwl_slot_mem
    import brwl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_slot_wr i_wr,
    input  wire t_idx     i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [TABLE_ENTRIES];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/block_reader_writer_lock_table_unit.sv */
// ----------------------------------------------------------------------------
// block_reader_writer_lock_table_unit
// Shared/exclusive lock table over block positions plus a whole-store lock.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A whole-store
// request keeps busy high only for the decide and write-back step; a position
// request first runs the key compare that walks the slot store one slot per
// cycle through its single read port, then waits for the last read to come
// back, then decides and writes back. The result appears for one cycle with
// o_valid in the first cycle that busy is low; it cannot be held off, so it
// must be taken then. The totals ports always show the current lock totals.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module block_reader_writer_lock_table_unit
    import brwl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_cmd     i_cmd,
    input  wire logic     i_whole_store,
    input  wire t_pos     i_position,
    output logic          o_valid,
    output logic          o_granted,
    output t_status       o_status,
    output t_out_cnt      o_total_readers,
    output t_out_cnt      o_total_writers
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]               r_state, n_state;
    t_idx                     r_idx, n_idx;
    t_cmd                     r_cmd, n_cmd;
    logic                     r_whole, n_whole;
    t_key                     r_key, n_key;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    t_count                   r_whole_rd, n_whole_rd;
    t_count                   r_whole_wr, n_whole_wr;
    t_count                   r_reader_total, n_reader_total;
    t_count                   r_writer_total, n_writer_total;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_status, n_status;
    logic                     r_granted;

    // scan results
    logic   r_rd_live;
    t_idx   r_rd_idx;
    logic   r_found;
    t_idx   r_slot_idx;
    t_count r_slot_rd;
    t_count r_slot_wr;
    logic   r_has_free;
    t_idx   r_free_idx;

    t_slot    rd_data;
    t_slot_wr mem_wr;
    logic     accept;
    logic     is_read;
    logic     is_lock;
    t_count   sel_cnt;
    t_count   sel_tot;
    t_count   new_rd;
    t_count   new_wr;
    logic     conflict;

    assign accept = start && (r_state == S_IDLE);

    brwl_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_cmd          = r_cmd;
        n_whole        = r_whole;
        n_key          = r_key;
        n_valid        = r_valid;
        n_whole_rd     = r_whole_rd;
        n_whole_wr     = r_whole_wr;
        n_reader_total = r_reader_total;
        n_writer_total = r_writer_total;
        n_out_valid    = 1'b0;
        n_status       = r_status;
        mem_wr         = '0;
        is_read        = ~r_cmd[0];
        is_lock        = ~r_cmd[1];
        sel_cnt        = is_read ? r_slot_rd : r_slot_wr;
        sel_tot        = is_read ? r_reader_total : r_writer_total;
        new_rd         = r_found ? r_slot_rd : '0;
        new_wr         = r_found ? r_slot_wr : '0;
        conflict       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_whole = i_whole_store;
                    n_key   = key_of(i_position);
                    n_idx   = '0;
                    n_state = i_whole_store ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = t_idx'(r_idx + 1'b1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_status    = ST_DONE;
                if (r_whole) begin
                    case (r_cmd)
                        CMD_READ_LOCK: begin
                            if (r_writer_total != '0) begin
                                n_status = ST_CONFLICT;
                            end else if (r_whole_rd == COUNT_MAX ||
                                         r_reader_total == COUNT_MAX) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_whole_rd     = t_count'(r_whole_rd + 1'b1);
                                n_reader_total = t_count'(r_reader_total + 1'b1);
                            end
                        end
                        CMD_WRITE_LOCK: begin
                            if (r_reader_total != '0 || r_writer_total != '0) begin
                                n_status = ST_CONFLICT;
                            end else if (r_whole_wr == COUNT_MAX ||
                                         r_writer_total == COUNT_MAX) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_whole_wr     = t_count'(r_whole_wr + 1'b1);
                                n_writer_total = t_count'(r_writer_total + 1'b1);
                            end
                        end
                        CMD_READ_UNLOCK: begin
                            if (r_whole_rd == '0) begin
                                n_status = ST_NOT_HELD;
                            end else begin
                                n_whole_rd = t_count'(r_whole_rd - 1'b1);
                                if (r_reader_total != '0) begin
                                    n_reader_total = t_count'(r_reader_total - 1'b1);
                                end
                            end
                        end
                        default: begin
                            if (r_whole_wr == '0) begin
                                n_status = ST_NOT_HELD;
                            end else begin
                                n_whole_wr = t_count'(r_whole_wr - 1'b1);
                                if (r_writer_total != '0) begin
                                    n_writer_total = t_count'(r_writer_total - 1'b1);
                                end
                            end
                        end
                    endcase
                end else if (is_lock) begin
                    if (is_read) begin
                        conflict = (r_whole_wr != '0) || (r_found && r_slot_wr != '0);
                    end else begin
                        conflict = (r_whole_rd != '0) || (r_whole_wr != '0) || r_found;
                    end
                    if (conflict) begin
                        n_status = ST_CONFLICT;
                    end else if (sel_tot == COUNT_MAX || (r_found && sel_cnt == COUNT_MAX)) begin
                        n_status = ST_OVERFLOW;
                    end else if (!r_found && !r_has_free) begin
                        n_status = ST_FULL;
                    end else begin
                        if (is_read) begin
                            new_rd         = t_count'(new_rd + 1'b1);
                            n_reader_total = t_count'(r_reader_total + 1'b1);
                        end else begin
                            new_wr         = t_count'(new_wr + 1'b1);
                            n_writer_total = t_count'(r_writer_total + 1'b1);
                        end
                        mem_wr.en           = 1'b1;
                        mem_wr.addr         = r_found ? r_slot_idx : r_free_idx;
                        mem_wr.data.key     = r_key;
                        mem_wr.data.readers = new_rd;
                        mem_wr.data.writers = new_wr;
                        n_valid[mem_wr.addr] = 1'b1;
                    end
                end else begin
                    if (!r_found || sel_cnt == '0) begin
                        n_status = ST_NOT_HELD;
                    end else begin
                        if (is_read) begin
                            new_rd = t_count'(new_rd - 1'b1);
                            if (r_reader_total != '0) begin
                                n_reader_total = t_count'(r_reader_total - 1'b1);
                            end
                        end else begin
                            new_wr = t_count'(new_wr - 1'b1);
                            if (r_writer_total != '0) begin
                                n_writer_total = t_count'(r_writer_total - 1'b1);
                            end
                        end
                        mem_wr.en           = 1'b1;
                        mem_wr.addr         = r_slot_idx;
                        mem_wr.data.key     = r_key;
                        mem_wr.data.readers = new_rd;
                        mem_wr.data.writers = new_wr;
                        // last holder gone: slot is free again
                        if (new_rd == '0 && new_wr == '0) begin
                            n_valid[r_slot_idx] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_valid        <= '0;
            r_whole_rd     <= '0;
            r_whole_wr     <= '0;
            r_reader_total <= '0;
            r_writer_total <= '0;
            r_out_valid    <= 1'b0;
            r_rd_live      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_valid        <= n_valid;
            r_whole_rd     <= n_whole_rd;
            r_whole_wr     <= n_whole_wr;
            r_reader_total <= n_reader_total;
            r_writer_total <= n_writer_total;
            r_out_valid    <= n_out_valid;
            r_rd_live      <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmd     <= n_cmd;
        r_whole   <= n_whole;
        r_key     <= n_key;
        r_status  <= n_status;
        r_granted <= (n_status == ST_DONE);
        r_rd_idx  <= r_idx;
    end

    // compare the slot read last cycle against the requested key;
    // first match and lowest free slot are kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || accept) begin
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
        end else if (r_rd_live) begin
            if (!r_found && r_valid[r_rd_idx] && rd_data.key == r_key) begin
                r_found <= 1'b1;
            end
            if (!r_has_free && !r_valid[r_rd_idx]) begin
                r_has_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_live && !r_found && r_valid[r_rd_idx] && rd_data.key == r_key) begin
            r_slot_idx <= r_rd_idx;
            r_slot_rd  <= rd_data.readers;
            r_slot_wr  <= rd_data.writers;
        end
        if (r_rd_live && !r_has_free && !r_valid[r_rd_idx]) begin
            r_free_idx <= r_rd_idx;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_granted       = r_granted;
    assign o_status        = r_status;
    assign o_total_readers = count_out(r_reader_total);
    assign o_total_writers = count_out(r_writer_total);

endmodule

`default_nettype wire

/* src/brwl_checker.sv */
// ----------------------------------------------------------------------------
// brwl_checker
// Port-level lock table checks: strobe timing, grant, busy on accept, totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_reader_writer_lock_table_unit_assert.svh"

module brwl_checker
    import brwl_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     o_valid,
    input wire logic     o_granted,
    input wire t_status  o_status,
    input wire t_out_cnt o_total_readers,
    input wire t_out_cnt o_total_writers
);

    `BRWL_ASSERT_SAME(a_granted_match, i_clk, i_rst_n, o_valid, o_granted == (o_status == ST_DONE), "granted disagrees with status")

    // a refused request leaves the totals untouched
    `BRWL_ASSERT_SAME(a_refused_totals, i_clk, i_rst_n, o_valid && !o_granted, $stable(o_total_readers) && $stable(o_total_writers), "totals moved on a refused item")

    `BRWL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")

    `BRWL_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")

    `BRWL_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")

endmodule

bind block_reader_writer_lock_table_unit brwl_checker u_brwl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_granted       (o_granted),
    .o_status        (o_status),
    .o_total_readers (o_total_readers),
    .o_total_writers (o_total_writers)
);

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the block lock table against a cycle-free model of its lock rules.
// Requests go in over start/busy, and each strobed reply is compared field
// by field with the reply that the model works out once busy drops again.
// Directed rule checks and a full table come first, then random lock/unlock
// traffic under three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import brwl_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          POOL_SIZE   = 24;

    typedef struct {
        logic     granted;
        t_status  status;
        t_out_cnt readers;
        t_out_cnt writers;
    } lock_reply_t;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_cmd     i_cmd = CMD_READ_LOCK;
    logic     i_whole_store = 1'b0;
    t_pos     i_position = '0;
    logic     busy;
    logic     o_valid;
    logic     o_granted;
    t_status  o_status;
    t_out_cnt o_total_readers;
    t_out_cnt o_total_writers;

    // model state
    logic   tbl_used [TABLE_ENTRIES];
    t_key   tbl_key [TABLE_ENTRIES];
    t_count tbl_readers [TABLE_ENTRIES];
    t_count tbl_writers [TABLE_ENTRIES];
    t_count store_readers = '0;
    t_count store_writers = '0;
    t_count readers_held = '0;
    t_count writers_held = '0;

    lock_reply_t pending_replies[$];
    lock_reply_t seen_reply;
    t_key        key_pool [POOL_SIZE];
    int          idle_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    block_reader_writer_lock_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_whole_store   (i_whole_store),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .o_granted       (o_granted),
        .o_status        (o_status),
        .o_total_readers (o_total_readers),
        .o_total_writers (o_total_writers)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Applies one request to the model and returns its status.
    function automatic t_status resolve_request(t_cmd c, logic whole, t_pos pos);
        t_key key;
        int   hit;
        int   spare;
        logic is_rd;
        key = pos[KEY_BITS-1:0];
        if (whole) begin
            case (c)
                CMD_READ_LOCK: begin
                    if (writers_held != 0) return ST_CONFLICT;
                    if (store_readers == COUNT_MAX || readers_held == COUNT_MAX)
                        return ST_OVERFLOW;
                    store_readers++;
                    readers_held++;
                    return ST_DONE;
                end
                CMD_WRITE_LOCK: begin
                    if (readers_held != 0 || writers_held != 0) return ST_CONFLICT;
                    if (store_writers == COUNT_MAX || writers_held == COUNT_MAX)
                        return ST_OVERFLOW;
                    store_writers++;
                    writers_held++;
                    return ST_DONE;
                end
                CMD_READ_UNLOCK: begin
                    if (store_readers == 0) return ST_NOT_HELD;
                    store_readers--;
                    if (readers_held != 0) readers_held--;
                    return ST_DONE;
                end
                default: begin // write unlock
                    if (store_writers == 0) return ST_NOT_HELD;
                    store_writers--;
                    if (writers_held != 0) writers_held--;
                    return ST_DONE;
                end
            endcase
        end

        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_used[i] && tbl_key[i] == key) hit = i;
        is_rd = (c == CMD_READ_LOCK || c == CMD_READ_UNLOCK);

        if (c == CMD_READ_LOCK || c == CMD_WRITE_LOCK) begin
            if (is_rd) begin
                // position is checked even while the store lock holds readers
                if (store_writers != 0) return ST_CONFLICT;
                if (hit >= 0 && tbl_writers[hit] != 0) return ST_CONFLICT;
            end else begin
                if (store_readers != 0 || store_writers != 0) return ST_CONFLICT;
                if (hit >= 0) return ST_CONFLICT;
            end
            if ((is_rd ? readers_held : writers_held) == COUNT_MAX) return ST_OVERFLOW;
            if (hit >= 0) begin
                if ((is_rd ? tbl_readers[hit] : tbl_writers[hit]) == COUNT_MAX)
                    return ST_OVERFLOW;
            end else begin
                spare = -1;
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!tbl_used[i]) spare = i;
                if (spare < 0) return ST_FULL;
                tbl_used[spare]    = 1'b1;
                tbl_key[spare]     = key;
                tbl_readers[spare] = '0;
                tbl_writers[spare] = '0;
                hit = spare;
            end
            if (is_rd) begin
                tbl_readers[hit]++;
                readers_held++;
            end else begin
                tbl_writers[hit]++;
                writers_held++;
            end
            return ST_DONE;
        end

        if (hit < 0) return ST_NOT_HELD;
        if (is_rd) begin
            if (tbl_readers[hit] == 0) return ST_NOT_HELD;
            tbl_readers[hit]--;
            if (readers_held != 0) readers_held--;
        end else begin
            if (tbl_writers[hit] == 0) return ST_NOT_HELD;
            tbl_writers[hit]--;
            if (writers_held != 0) writers_held--;
        end
        if (tbl_readers[hit] == 0 && tbl_writers[hit] == 0) tbl_used[hit] = 1'b0;
        return ST_DONE;
    endfunction

    function automatic t_pos random_position();
        return t_pos'({$urandom(), $urandom()});
    endfunction

    // Sends one item, waits for it to be taken and queues the reply it must get.
    task automatic send_request(t_cmd c, logic whole, t_pos pos);
        lock_reply_t reply;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        i_whole_store <= whole;
        i_position    <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        reply.status  = resolve_request(c, whole, pos);
        reply.granted = (reply.status == ST_DONE);
        reply.readers = readers_held;
        reply.writers = writers_held;
        pending_replies.push_back(reply);
    endtask

    // Unlocks everything the model says is held.
    task automatic release_all();
        logic   used [TABLE_ENTRIES];
        t_key   keys [TABLE_ENTRIES];
        t_count rds [TABLE_ENTRIES];
        t_count wrs [TABLE_ENTRIES];
        t_count wh_rd;
        t_count wh_wr;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            used[i] = tbl_used[i];
            keys[i] = tbl_key[i];
            rds[i]  = tbl_readers[i];
            wrs[i]  = tbl_writers[i];
        end
        wh_rd = store_readers;
        wh_wr = store_writers;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (used[i]) begin
                repeat (rds[i]) send_request(CMD_READ_UNLOCK, 1'b0, keys[i]);
                repeat (wrs[i]) send_request(CMD_WRITE_UNLOCK, 1'b0, keys[i]);
            end
        end
        repeat (wh_rd) send_request(CMD_READ_UNLOCK, 1'b1, random_position());
        repeat (wh_wr) send_request(CMD_WRITE_UNLOCK, 1'b1, random_position());
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                fail_count++;
                $error("reply with no request outstanding");
            end else begin
                seen_reply = pending_replies.pop_front();
                check_field("granted", 16'(seen_reply.granted), 16'(o_granted));
                check_field("status", 16'(seen_reply.status), 16'(o_status));
                check_field("total_readers", seen_reply.readers, o_total_readers);
                check_field("total_writers", seen_reply.writers, o_total_writers);
            end
        end
    end

    // Each lock rule in turn, on keys at the ends of the key range.
    task automatic test_lock_rules();
        t_pos key_a;
        t_pos key_b;
        t_pos key_c;
        t_pos key_d;
        key_a = '0;
        key_b = '1;
        key_c = {1'b1, {(POS_BITS-1){1'b0}}};
        key_d = t_pos'(1);
        send_request(CMD_READ_UNLOCK, 1'b0, key_a);
        send_request(CMD_WRITE_UNLOCK, 1'b1, key_b);
        send_request(CMD_READ_UNLOCK, 1'b1, key_a);
        send_request(CMD_READ_LOCK, 1'b0, key_a);
        send_request(CMD_READ_LOCK, 1'b0, key_a);
        send_request(CMD_WRITE_LOCK, 1'b0, key_a);
        send_request(CMD_WRITE_LOCK, 1'b1, key_a);
        send_request(CMD_READ_LOCK, 1'b1, key_c);
        send_request(CMD_READ_LOCK, 1'b0, key_b);
        send_request(CMD_WRITE_LOCK, 1'b0, key_c);
        send_request(CMD_WRITE_UNLOCK, 1'b0, key_a);
        send_request(CMD_READ_UNLOCK, 1'b1, key_b);
        // differs from key_a only in the top bit
        send_request(CMD_WRITE_LOCK, 1'b0, key_c);
        send_request(CMD_READ_LOCK, 1'b0, key_c);
        send_request(CMD_READ_LOCK, 1'b1, key_a);
        send_request(CMD_READ_UNLOCK, 1'b0, key_c);
        send_request(CMD_WRITE_UNLOCK, 1'b0, key_c);
        send_request(CMD_READ_UNLOCK, 1'b0, key_a);
        send_request(CMD_READ_UNLOCK, 1'b0, key_a);
        send_request(CMD_READ_UNLOCK, 1'b0, key_b);
        send_request(CMD_WRITE_LOCK, 1'b1, key_d);
        send_request(CMD_READ_LOCK, 1'b0, key_d);
        send_request(CMD_WRITE_LOCK, 1'b0, key_d);
        send_request(CMD_WRITE_LOCK, 1'b1, key_b);
        send_request(CMD_WRITE_UNLOCK, 1'b1, key_c);
        send_request(CMD_WRITE_UNLOCK, 1'b0, key_d);
    endtask

    task automatic test_table_full();
        t_pos keys [TABLE_ENTRIES];
        t_pos base;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            base    = random_position();
            keys[i] = {base[POS_BITS-1:IDX_BITS], t_idx'(i)};
            send_request((i % 2 == 0) ? CMD_WRITE_LOCK : CMD_READ_LOCK, 1'b0, keys[i]);
        end
        send_request(CMD_READ_LOCK, 1'b0, random_position());
        send_request(CMD_WRITE_LOCK, 1'b0, random_position());
        send_request(CMD_READ_LOCK, 1'b0, keys[1]);
        release_all();
    endtask

    task automatic test_random_traffic(int count);
        int   held [$];
        int   pick;
        t_cmd c;
        logic whole;
        t_pos pos;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) == 0) release_all();
            pick  = $urandom_range(99);
            c     = (pick < 32) ? CMD_READ_LOCK :
                    (pick < 52) ? CMD_WRITE_LOCK :
                    (pick < 80) ? CMD_READ_UNLOCK : CMD_WRITE_UNLOCK;
            whole = ($urandom_range(99) < 12);
            held.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (tbl_used[i]) held.push_back(i);
            if (whole || $urandom_range(9) == 0)
                pos = random_position();
            else if ((c == CMD_READ_UNLOCK || c == CMD_WRITE_UNLOCK) && held.size() != 0
                     && $urandom_range(99) < 80)
                pos = tbl_key[held[$urandom_range(held.size() - 1)]];
            else
                pos = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_request(c, whole, pos);
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_used[i]    = 1'b0;
            tbl_key[i]     = '0;
            tbl_readers[i] = '0;
            tbl_writers[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {1'b1, {(KEY_BITS-1){1'b0}}};
        key_pool[3] = t_key'(1);
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = random_position();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 37;
        test_lock_rules();
        test_table_full();
        test_random_traffic(340);
        idle_pct = 63;
        test_random_traffic(330);
        idle_pct = 0;
        test_random_traffic(330);

        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
